[rtl/core/rcz_pkg.sv]
// rcz_pkg: shared types, constants and helpers of the rolling change z-score block
// no dependencies
`default_nettype none

package rcz_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = PTR_W + 1;
  localparam int CFG_W      = 9;
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(30);

  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] a;
    logic [31:0] b;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [63:0] result;
  } unit_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHG_GO,
    S_CHG_WAIT,
    S_ACCUM,
    S_SMOOTH_GO,
    S_SMOOTH_WAIT,
    S_DROP,
    S_SQ_GO,
    S_SQ_WAIT,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_ESQ_GO,
    S_ESQ_WAIT,
    S_M2_GO,
    S_M2_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_Z_GO,
    S_Z_WAIT,
    S_OUT
  } state_t;

  // signed saturation of a sign and magnitude pair
  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) r = 32'sh7fff_ffff;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rcz_if.sv]
// rcz_if: valid/ready channels for price samples and results
// depends on nothing
`default_nettype none

interface rcz_price_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface rcz_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] smoothed_change;
  logic signed [31:0] zscore;
  logic               degenerate;
  modport source (output valid, output smoothed_change, output zscore, output degenerate,
                  input ready);
  modport sink (input valid, input smoothed_change, input zscore, input degenerate,
                output ready);
endinterface

`default_nettype wire

[rtl/core/rcz_ram.sv]
// rcz_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module rcz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/rcz_serial_unit.sv]
// rcz_serial_unit: shared bit-serial divider, multiplier and square root
// depends on rcz_pkg
`default_nettype none

module rcz_serial_unit (
  input  logic              clk,
  input  logic              rst,
  input  rcz_pkg::unit_req_t req,
  output rcz_pkg::unit_rsp_t rsp
);
  import rcz_pkg::*;

  logic [63:0] sh;
  logic [31:0] den;
  logic [33:0] acc;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  op_t         op;

  logic [33:0] div_t;
  logic        div_ge;
  logic [33:0] div_r;
  logic [32:0] mul_s;
  logic [35:0] sq_t;
  logic [35:0] sq_trial;
  logic        sq_ge;

  always_comb begin
    div_t    = {acc[32:0], sh[63]};
    div_ge   = div_t >= {2'b00, den};
    div_r    = div_ge ? div_t - {2'b00, den} : div_t;
    mul_s    = {1'b0, sh[63:32]} + (sh[0] ? {1'b0, den} : 33'd0);
    sq_t     = {acc, sh[63:62]};
    sq_trial = {2'b00, den, 2'b01};
    sq_ge    = sq_t >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        acc  <= '0;
        case (req.op)
          OP_MUL: begin
            sh  <= {32'd0, req.b};
            den <= req.a[31:0];
            cnt <= 7'd32;
          end
          OP_SQRT: begin
            sh  <= req.a;
            den <= '0;
            cnt <= 7'd32;
          end
          default: begin
            sh  <= req.a;
            den <= req.b;
            cnt <= 7'd64;
          end
        endcase
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            sh <= {mul_s, sh[31:1]};
          end
          OP_SQRT: begin
            sh  <= {sh[61:0], 2'b00};
            acc <= sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
            den <= {den[30:0], sq_ge};
          end
          default: begin
            sh  <= {sh[62:0], div_ge};
            acc <= div_r;
          end
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.busy   = busy;
  assign rsp.result = (op == OP_SQRT) ? {32'd0, den} : sh;

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start && !busy |=> busy)
    else $error("unit did not start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a finished operation");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == 7'd0)
    else $error("count left over while idle");
`endif

endmodule

`default_nettype wire

[rtl/core/rolling_change_zscore.sv]
// rolling_change_zscore: percent change, moving average and running z-score
// depends on rcz_pkg, rcz_if, rcz_ram, rcz_serial_unit
//
// sample (sink): one 32-bit unsigned price per transaction, taken only while
// the block is idle. result (source): smoothed change and z-score, both
// signed Q16.16, plus a degenerate flag; one transaction per sample once the
// window has filled, none before.
// cfg_we/cfg_wdata set the window length (reset 30, 0 acts as 1, above 256
// as 256); a write restarts the window but keeps price history and stats.
// Sequencing: one shared bit-serial unit does every divide, square and square
// root. A sample that fills no window uses at most one divide; one that gives
// a result uses up to five divides, two squares and one root, and the block
// is ready for the next sample in the same cycle as that result turns valid.
// The result sits in an output register; the next sample is taken while it
// waits. A stalled receiver holds the block only when a new result is ready
// to replace the waiting one.
// Reset (synchronous rst) clears all history and statistics; the ring store
// needs no clearing since only written entries are read.
`default_nettype none

module rolling_change_zscore (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rcz_pkg::CFG_W-1:0] cfg_wdata,
  rcz_price_if.sink                 sample,
  rcz_result_if.source              result
);
  import rcz_pkg::*;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]  window_length;
  logic [31:0]       prev_price;
  logic              seen_first;
  logic [PTR_W-1:0]  ptr;
  logic signed [40:0] window_sum;
  logic [WIN_W-1:0]  fill_count;
  logic [31:0]       smoothed_count;
  logic signed [63:0] smoothed_sum;
  logic [63:0]       square_sum;

  logic [31:0]       price_q;
  logic signed [31:0] change;
  logic              chg_neg;
  logic              zero_prev;
  logic [PTR_W-1:0]  old_addr;
  logic signed [31:0] smooth;
  logic              mean_neg;
  logic [31:0]       mean_mag;
  logic [63:0]       esq;
  logic [63:0]       variance;
  logic [31:0]       dev;
  logic              z_neg;
  logic signed [31:0] z_val;
  logic              degen;

  logic              res_valid;
  logic signed [31:0] res_smooth;
  logic signed [31:0] res_z;
  logic              res_degen;

  unit_req_t         req;
  unit_rsp_t         rsp;
  logic [31:0]       ring_rdata;

  logic [WIN_W-1:0]  w_eff;
  logic [WIN_W-1:0]  fill_next;
  logic [31:0]       chg_mag;
  logic [38:0]       chg_m100;
  logic [40:0]       ws_mag;
  logic [31:0]       smooth_mag;
  logic [63:0]       sum_mag;
  logic signed [33:0] mean34;
  logic signed [33:0] diff;
  logic [33:0]       diff_mag;
  logic [63:0]       m2;
  logic [64:0]       sq_add;
  logic              degen_now;

  always_comb begin
    if (window_length == '0) w_eff = WIN_W'(1);
    else if (32'(window_length) > 32'(MAX_WINDOW)) w_eff = WIN_W'(MAX_WINDOW);
    else w_eff = WIN_W'(window_length);
    fill_next  = (fill_count < w_eff) ? fill_count + WIN_W'(1) : fill_count;
    chg_mag    = (price_q < prev_price) ? prev_price - price_q : price_q - prev_price;
    chg_m100   = {1'b0, chg_mag, 6'd0} + {2'b00, chg_mag, 5'd0} + {5'd0, chg_mag, 2'd0};
    ws_mag     = window_sum[40] ? 41'(-window_sum) : 41'(window_sum);
    smooth_mag = smooth[31] ? 32'(-smooth) : 32'(smooth);
    sum_mag    = smoothed_sum[63] ? 64'(-smoothed_sum) : 64'(smoothed_sum);
    mean34     = mean_neg ? -$signed({2'b00, mean_mag}) : $signed({2'b00, mean_mag});
    diff       = 34'(34'(smooth) - mean34);
    diff_mag   = diff[33] ? 34'(-diff) : 34'(diff);
    m2         = {8'd0, rsp.result[63:8]};
    sq_add     = {1'b0, square_sum} + {9'd0, rsp.result[63:8]};
    degen_now  = zero_prev || (dev == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req        = '0;
    req.op     = OP_DIV;
    unique case (state)
      S_IDLE: begin
        if (sample.valid) state_next = S_CHG_GO;
      end
      S_CHG_GO: begin
        if (seen_first && prev_price != 32'd0) begin
          req.start  = 1'b1;
          req.a      = 64'({chg_m100, 16'd0});
          req.b      = prev_price;
          state_next = S_CHG_WAIT;
        end else begin
          state_next = S_ACCUM;
        end
      end
      S_CHG_WAIT: begin
        if (rsp.done) state_next = S_ACCUM;
      end
      S_ACCUM: begin
        if (fill_next < w_eff) state_next = S_IDLE;
        else state_next = S_SMOOTH_GO;
      end
      S_SMOOTH_GO: begin
        req.start  = 1'b1;
        req.a      = 64'(ws_mag);
        req.b      = 32'(w_eff);
        state_next = S_SMOOTH_WAIT;
      end
      S_SMOOTH_WAIT: begin
        if (rsp.done) state_next = S_DROP;
      end
      S_DROP: begin
        state_next = S_SQ_GO;
      end
      S_SQ_GO: begin
        req.start  = 1'b1;
        req.op     = OP_MUL;
        req.a      = 64'(smooth_mag);
        req.b      = smooth_mag;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (rsp.done) state_next = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        req.start  = 1'b1;
        req.a      = sum_mag;
        req.b      = smoothed_count;
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (rsp.done) state_next = S_ESQ_GO;
      end
      S_ESQ_GO: begin
        req.start  = 1'b1;
        req.a      = square_sum;
        req.b      = smoothed_count;
        state_next = S_ESQ_WAIT;
      end
      S_ESQ_WAIT: begin
        if (rsp.done) state_next = S_M2_GO;
      end
      S_M2_GO: begin
        req.start  = 1'b1;
        req.op     = OP_MUL;
        req.a      = 64'(mean_mag);
        req.b      = mean_mag;
        state_next = S_M2_WAIT;
      end
      S_M2_WAIT: begin
        if (rsp.done) state_next = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        req.start  = 1'b1;
        req.op     = OP_SQRT;
        req.a      = variance;
        state_next = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (rsp.done) state_next = S_Z_GO;
      end
      S_Z_GO: begin
        if (degen_now) begin
          state_next = S_OUT;
        end else begin
          req.start  = 1'b1;
          req.a      = 64'({diff_mag, 12'd0});
          req.b      = dev;
          state_next = S_Z_WAIT;
        end
      end
      S_Z_WAIT: begin
        if (rsp.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!res_valid || result.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_RESET;
      prev_price     <= '0;
      seen_first     <= 1'b0;
      ptr            <= '0;
      window_sum     <= '0;
      fill_count     <= '0;
      smoothed_count <= '0;
      smoothed_sum   <= '0;
      square_sum     <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (res_valid && result.ready && state != S_OUT) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample.valid) price_q <= sample.price;
        end
        S_CHG_GO: begin
          zero_prev <= seen_first && prev_price == 32'd0;
          change    <= '0;
          chg_neg   <= price_q < prev_price;
        end
        S_CHG_WAIT: begin
          if (rsp.done) change <= sat32(chg_neg, rsp.result);
        end
        S_ACCUM: begin
          prev_price <= price_q;
          seen_first <= 1'b1;
          window_sum <= window_sum + 41'(change);
          fill_count <= fill_next;
          old_addr   <= ptr - w_eff[PTR_W-1:0] + PTR_W'(1);
          if (fill_next < w_eff) ptr <= ptr + PTR_W'(1);
        end
        S_SMOOTH_WAIT: begin
          if (rsp.done) smooth <= sat32(window_sum[40], rsp.result);
        end
        S_DROP: begin
          window_sum <= window_sum - 41'($signed(ring_rdata));
          ptr        <= ptr + PTR_W'(1);
        end
        S_SQ_WAIT: begin
          if (rsp.done && smoothed_count != 32'hffff_ffff) begin
            smoothed_count <= smoothed_count + 32'd1;
            smoothed_sum   <= smoothed_sum + 64'(smooth);
            square_sum     <= sq_add[64] ? 64'hffff_ffff_ffff_ffff : sq_add[63:0];
          end
        end
        S_MEAN_WAIT: begin
          if (rsp.done) begin
            mean_neg <= smoothed_sum[63];
            mean_mag <= rsp.result[31:0];
          end
        end
        S_ESQ_WAIT: begin
          if (rsp.done) esq <= rsp.result;
        end
        S_M2_WAIT: begin
          if (rsp.done) variance <= (esq > m2) ? esq - m2 : 64'd0;
        end
        S_ROOT_WAIT: begin
          if (rsp.done) dev <= rsp.result[31:0];
        end
        S_Z_GO: begin
          degen <= degen_now;
          z_neg <= diff[33];
          z_val <= '0;
        end
        S_Z_WAIT: begin
          if (rsp.done) z_val <= sat32(z_neg, rsp.result);
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_smooth <= smooth;
            res_z      <= z_val;
            res_degen  <= degen;
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        window_length <= cfg_wdata;
        ptr           <= '0;
        window_sum    <= '0;
        fill_count    <= '0;
      end
    end
  end

  rcz_ram #(
    .WIDTH(32),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (state == S_ACCUM),
    .waddr(ptr),
    .wdata(change),
    .raddr(old_addr),
    .rdata(ring_rdata)
  );

  rcz_serial_unit u_unit (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  assign sample.ready           = (state == S_IDLE);
  assign result.valid           = res_valid;
  assign result.smoothed_change = res_smooth;
  assign result.zscore          = res_z;
  assign result.degenerate      = res_degen;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> fill_count <= w_eff)
    else $error("fill count beyond window");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_degen |-> res_z == 32'sd0)
    else $error("degenerate result with nonzero zscore");
  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_CHG_WAIT || state == S_SMOOTH_WAIT || state == S_SQ_WAIT ||
                 state == S_MEAN_WAIT || state == S_ESQ_WAIT || state == S_M2_WAIT ||
                 state == S_ROOT_WAIT || state == S_Z_WAIT)
    else $error("unit finished outside a wait state");
  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("unit started while busy");
`endif

endmodule

`default_nettype wire

[bench/rcz_checker.sv]
// rcz_checker: watches the price and result channels, predicts each result
// depends on rcz_pkg and rcz_if; window writes are observed on cfg_we/cfg_wdata
`timescale 1ns / 100ps

module rcz_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rcz_pkg::CFG_W-1:0] cfg_wdata,
  rcz_price_if.sink                 sample,
  rcz_result_if.sink                result,
  output int                        errors,
  output int                        pending,
  output int                        results_seen
);

  typedef struct packed {
    logic signed [31:0] smooth;
    logic signed [31:0] z;
    logic               degen;
  } zresult_t;

  zresult_t        expected_q[$];
  logic [8:0]      win_len;
  logic [31:0]     last_price;
  bit              have_first;
  logic signed [31:0] ring[rcz_pkg::MAX_WINDOW];
  int unsigned     ptr;
  longint          win_sum;
  int unsigned     fill;
  longint unsigned stat_count;
  longint          stat_sum;
  longint unsigned stat_sq_sum;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned abs_sq(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    return m * m;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_price(input logic [31:0] p);
    longint chg, mean, d;
    longint unsigned w, sq, esq, m2, var_v, dev;
    bit zp;
    zresult_t r;
    chg = 0;
    zp = 0;
    w = win_len < 1 ? 1 : (win_len > rcz_pkg::MAX_WINDOW ? rcz_pkg::MAX_WINDOW : win_len);
    if (have_first) begin
      if (last_price == 0) zp = 1;
      else chg = longint'(clamp32(((longint'(p) - longint'(last_price)) * 6553600)
                                  / longint'(last_price)));
    end
    have_first = 1;
    last_price = p;
    ring[ptr % rcz_pkg::MAX_WINDOW] = 32'(chg);
    win_sum += chg;
    if (fill < w) fill++;
    if (fill < w) begin
      ptr = (ptr + 1) % rcz_pkg::MAX_WINDOW;
      return;
    end
    r.smooth = clamp32(win_sum / longint'(w));
    win_sum -= longint'(ring[(ptr + rcz_pkg::MAX_WINDOW - (w - 1)) % rcz_pkg::MAX_WINDOW]);
    ptr = (ptr + 1) % rcz_pkg::MAX_WINDOW;
    if (stat_count < 64'hffff_ffff) begin
      sq = abs_sq(longint'(r.smooth)) >> 8;
      stat_count++;
      stat_sum += longint'(r.smooth);
      stat_sq_sum = (stat_sq_sum > ~64'd0 - sq) ? ~64'd0 : stat_sq_sum + sq;
    end
    mean = stat_sum / longint'(stat_count);
    esq = stat_sq_sum / stat_count;
    m2 = abs_sq(mean) >> 8;
    var_v = esq > m2 ? esq - m2 : 0;
    dev = isqrt(var_v);
    r.degen = zp || dev == 0;
    r.z = 0;
    if (!r.degen) begin
      d = longint'(r.smooth) - mean;
      r.z = clamp32((d * 4096) / longint'(dev));
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  always @(posedge clk) begin
    zresult_t e;
    if (rst) begin
      win_len = rcz_pkg::WINDOW_RESET;
      last_price = 0;
      have_first = 0;
      ptr = 0;
      win_sum = 0;
      fill = 0;
      stat_count = 0;
      stat_sum = 0;
      stat_sq_sum = 0;
      expected_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        win_len = cfg_wdata;
        ptr = 0;
        win_sum = 0;
        fill = 0;
      end
      if (sample.valid && sample.ready) predict_price(sample.price);
      if (result.valid && result.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h %h %b",
            result.smoothed_change, result.zscore, result.degenerate);
        end else begin
          e = expected_q.pop_front();
          if (e.smooth !== result.smoothed_change || e.z !== result.zscore ||
              e.degen !== result.degenerate) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected smooth %h z %h degen %b, got %h %h %b",
                e.smooth, e.z, e.degen, result.smoothed_change, result.zscore,
                result.degenerate);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

[bench/testbench.sv]
// testbench: stimulus and verdict for rolling_change_zscore
// depends on rcz_pkg, rcz_if, rcz_checker and the block itself
`timescale 1ns / 100ps

module testbench;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [rcz_pkg::CFG_W-1:0] cfg_wdata = '0;
  int errors, pending, results_seen;
  int cycles = 0;
  bit quiet = 0;
  bit hold_off = 0;
  int items_sent = 0;

  rcz_price_if  price_ch();
  rcz_result_if result_ch();

  initial begin
    price_ch.valid = 0;
    price_ch.price = '0;
    result_ch.ready = 0;
  end

  rolling_change_zscore i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sample(price_ch.sink), .result(result_ch.source)
  );

  rcz_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sample(price_ch.sink), .result(result_ch.sink),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("timeout");
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        result_ch.ready <= 0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        result_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        result_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_price(input logic [31:0] p);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      price_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
    price_ch.valid <= 1;
    price_ch.price <= p;
    @(posedge clk);
    while (!price_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_and_set(input logic [8:0] w);
    price_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] walk(input logic [31:0] p);
    longint v;
    v = longint'(p) + $signed($urandom_range(0, 2000)) - 1000;
    if (v < 1) v = 1;
    return v[31:0];
  endfunction

  initial begin
    logic [31:0] p;
    int wins[8] = '{1, 2, 0, 256, 300, 5, 17, 3};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, zero previous price, big jumps
    send_price(32'd0);
    send_price(32'd100);
    send_price(32'd0);
    send_price(32'hffff_ffff);
    send_price(32'd1);
    send_price(32'hffff_ffff);
    send_price(32'd1);
    repeat (25) send_price(32'd1000);
    drain_and_set(9'd1);
    send_price(32'd0);
    send_price(32'd0);
    send_price(32'd5);
    send_price(32'hffff_ffff);
    send_price(32'h8000_0000);
    send_price(32'd1);
    // pressure: sender keeps offering while receiver holds off
    hold_off = 1;
    repeat (30) send_price($urandom);
    for (int k = 0; k < 8; k++) begin
      drain_and_set(9'(wins[k]));
      p = $urandom_range(1000, 100000);
      repeat (wins[k] >= 256 ? 300 : 90) begin
        if ($urandom_range(0, 19) == 0) p = $urandom;
        else p = walk(p);
        if (k == 7 && items_sent > 1100) quiet = 1;
        send_price(p);
      end
    end
    quiet = 1;
    drain_and_set(9'd30);
    repeat (40) send_price($urandom_range(1, 50000));
    price_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    $display("sent %0d price samples over nine window settings, checked %0d results",
      items_sent, results_seen);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rcz_pkg.sv
rtl/core/rcz_if.sv
rtl/core/rcz_ram.sv
rtl/core/rcz_serial_unit.sv
rtl/core/rolling_change_zscore.sv
bench/rcz_checker.sv
bench/testbench.sv
